FILE: sv/welb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wraparound event log buffer package
// Depth, field widths, command codes and shared types of the event log.
// ----------------------------------------------------------------------------
package welb_pkg;

  localparam int LOG_DEPTH = 256;
  localparam int IDX_W     = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

  localparam int CMD_W   = 2;
  localparam int TAG_W   = 8;
  localparam int STAMP_W = 32;
  localparam int CODE_W  = 8;
  localparam int RIDX_W  = 8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CODE_W-1:0] START_CODE_RST = 8'd1;
  localparam logic [CODE_W-1:0] END_CODE_RST   = 8'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_START_CODE = 1'b0,
    REG_END_CODE   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
    logic [CODE_W-1:0]  code;
  } entry_t;

  typedef struct packed {
    logic [CODE_W-1:0] start_code;
    logic [CODE_W-1:0] end_code;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]   fill_count;
    logic               read_valid;
    logic [STAMP_W-1:0] read_stamp;
    logic [TAG_W-1:0]   read_tag;
    logic [CODE_W-1:0]  read_code;
    logic [STAMP_W-1:0] newest_stamp;
    logic [TAG_W-1:0]   newest_tag;
    logic [CODE_W-1:0]  newest_code;
    logic [STAMP_W-1:0] span_ms;
    logic [STAMP_W-1:0] tag_time_ms;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/welb_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Event log command channel
// Valid/ready channel that carries one command beat into the event log.
// ----------------------------------------------------------------------------
interface welb_in_if import welb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [TAG_W-1:0]   tag;
  logic [STAMP_W-1:0] stamp;
  logic [CODE_W-1:0]  event_code;
  logic [RIDX_W-1:0]  read_index;

  modport source (output valid, command, tag, stamp, event_code, read_index, input ready);
  modport sink   (input valid, command, tag, stamp, event_code, read_index, output ready);
endinterface
`default_nettype wire

FILE: sv/welb_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Event log result channel
// Valid/ready channel that carries one result beat out of the event log.
// ----------------------------------------------------------------------------
interface welb_out_if import welb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   fill_count;
  logic               read_valid;
  logic [STAMP_W-1:0] read_stamp;
  logic [TAG_W-1:0]   read_tag;
  logic [CODE_W-1:0]  read_code;
  logic [STAMP_W-1:0] newest_stamp;
  logic [TAG_W-1:0]   newest_tag;
  logic [CODE_W-1:0]  newest_code;
  logic [STAMP_W-1:0] span_ms;
  logic [STAMP_W-1:0] tag_time_ms;

  modport source (output valid, fill_count, read_valid, read_stamp, read_tag, read_code,
                  newest_stamp, newest_tag, newest_code, span_ms, tag_time_ms,
                  input ready);
  modport sink   (input valid, fill_count, read_valid, read_stamp, read_tag, read_code,
                  newest_stamp, newest_tag, newest_code, span_ms, tag_time_ms,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/welb_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Event log configuration registers
// APB-style register block holding the start and end outcome codes.
// ----------------------------------------------------------------------------
module welb_cfg import welb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  // Registers sit on word boundaries, so the word index is the top address bit.
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_START_CODE: cfg_d.start_code = pwdata[CODE_W-1:0];
        REG_END_CODE:   cfg_d.end_code   = pwdata[CODE_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_CODE: prdata = APB_DATA_W'(cfg_q.start_code);
      REG_END_CODE:   prdata = APB_DATA_W'(cfg_q.end_code);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code <= START_CODE_RST;
      cfg_q.end_code   <= END_CODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: sv/wraparound_event_log_buffer.sv
`default_nettype none
// Append, read and clear move from ST_IDLE to ST_RESP, which registers the result beat once the output is free.
// A command is accepted only in ST_IDLE, so the next one waits until that result is registered.
// A tag query walks the entries through the RAM read port, one a cycle, and stops early
// when a matching start and end pair is found.
// Reset clears the write pointer and fill count at once; the entry RAM is not cleared and
// needs no clearing pass. The start and end codes reset to 1 and 2.
// ----------------------------------------------------------------------------
// Wraparound event log buffer
// Ring of timestamped events in a synchronous RAM that overwrites its oldest
// entry when full, with indexed reads, tag duration queries and a clear.
// ----------------------------------------------------------------------------
module wraparound_event_log_buffer import welb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  welb_in_if.sink                    evt_i,
  welb_out_if.source                 res_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  cfg_t cfg;

  welb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Entry RAM
  entry_t             log_mem_q [LOG_DEPTH];
  entry_t             rdata_q;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  entry_t             mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      log_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= log_mem_q[mem_raddr];
    end
  end

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   wp_q, wp_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic               fetch_q, fetch_d;
  logic               rd_hit_q, rd_hit_d;
  logic               issue_q, issue_d;
  logic               have_start_q, have_start_d;
  logic               res_valid_q, res_valid_d;
  entry_t             newest_q, newest_d;
  logic [STAMP_W-1:0] oldest_q, oldest_d;
  logic [TAG_W-1:0]   qtag_q, qtag_d;
  logic [STAMP_W-1:0] t0_q, t0_d;
  logic [STAMP_W-1:0] ttime_q, ttime_d;
  res_t               res_q, res_d;

  logic               full;
  logic [IDX_W-1:0]   base;
  logic [IDX_W-1:0]   next_wp;
  logic               accept;
  logic               match;
  logic [STAMP_W-1:0] oldest_eff;

  // Oldest-first position to RAM slot; both operands are below the depth.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] b,
                                               input logic [CNT_W-1:0] p);
    logic [IDX_W:0] sum;
    sum = {1'b0, b} + (IDX_W+1)'(p);
    if (sum >= (IDX_W+1)'(LOG_DEPTH)) begin
      sum = sum - (IDX_W+1)'(LOG_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign full    = (total_q == CNT_W'(LOG_DEPTH));
  assign base    = full ? wp_q : '0;
  assign next_wp = (wp_q == IDX_W'(LOG_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign accept  = evt_i.valid && evt_i.ready;
  assign match   = issue_q && (rdata_q.tag == qtag_q);
  // After an append into a full ring the new oldest stamp arrives from the RAM.
  assign oldest_eff = fetch_q ? rdata_q.stamp : oldest_q;

  assign evt_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    total_d      = total_q;
    pos_d        = pos_q;
    fetch_d      = fetch_q;
    rd_hit_d     = rd_hit_q;
    issue_d      = issue_q;
    have_start_d = have_start_q;
    newest_d     = newest_q;
    oldest_d     = oldest_q;
    qtag_d       = qtag_q;
    t0_d         = t0_q;
    ttime_d      = ttime_q;
    res_d        = res_q;
    res_valid_d  = res_valid_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = wp_q;
    mem_raddr    = slot_of(base, pos_q);
    mem_wdata    = '{stamp: evt_i.stamp, tag: evt_i.tag, code: evt_i.event_code};

    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_hit_d = 1'b0;
          fetch_d  = 1'b0;
          ttime_d  = '0;
          state_d  = ST_RESP;
          case (cmd_e'(evt_i.command))
            CMD_APPEND: begin
              mem_we   = 1'b1;
              newest_d = mem_wdata;
              wp_d     = next_wp;
              if (total_q == '0) begin
                oldest_d = evt_i.stamp;
              end
              if (full) begin
                mem_re    = 1'b1;
                mem_raddr = next_wp;
                fetch_d   = 1'b1;
              end else begin
                total_d = total_q + 1'b1;
              end
            end
            CMD_READ: begin
              if (CNT_W'(evt_i.read_index) < total_q) begin
                rd_hit_d  = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = slot_of(base, CNT_W'(evt_i.read_index));
              end
            end
            CMD_QUERY: begin
              qtag_d       = evt_i.tag;
              pos_d        = '0;
              issue_d      = 1'b0;
              have_start_d = 1'b0;
              state_d      = ST_SCAN;
            end
            CMD_CLEAR: begin
              wp_d    = '0;
              total_d = '0;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end

      ST_SCAN: begin
        // Evaluate the entry fetched last cycle while fetching the next one.
        issue_d = 1'b0;
        if (match && !have_start_q && (rdata_q.code == cfg.start_code)) begin
          have_start_d = 1'b1;
          t0_d         = rdata_q.stamp;
        end
        if (match && have_start_q && (rdata_q.code == cfg.end_code)) begin
          ttime_d = rdata_q.stamp - t0_q;
          state_d = ST_RESP;
        end else if (pos_q < total_q) begin
          mem_re  = 1'b1;
          pos_d   = pos_q + 1'b1;
          issue_d = 1'b1;
        end else begin
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!res_valid_q || res_o.ready) begin
          res_d.fill_count   = total_q;
          res_d.read_valid   = rd_hit_q;
          res_d.read_stamp   = rd_hit_q ? rdata_q.stamp : '0;
          res_d.read_tag     = rd_hit_q ? rdata_q.tag : '0;
          res_d.read_code    = rd_hit_q ? rdata_q.code : '0;
          res_d.newest_stamp = (total_q != '0) ? newest_q.stamp : '0;
          res_d.newest_tag   = (total_q != '0) ? newest_q.tag : '0;
          res_d.newest_code  = (total_q != '0) ? newest_q.code : '0;
          res_d.span_ms      = (total_q >= CNT_W'(2)) ? newest_q.stamp - oldest_eff : '0;
          res_d.tag_time_ms  = ttime_q;
          res_valid_d        = 1'b1;
          oldest_d           = oldest_eff;
          fetch_d            = 1'b0;
          state_d            = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wp_q         <= '0;
      total_q      <= '0;
      pos_q        <= '0;
      fetch_q      <= 1'b0;
      rd_hit_q     <= 1'b0;
      issue_q      <= 1'b0;
      have_start_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wp_q         <= wp_d;
      total_q      <= total_d;
      pos_q        <= pos_d;
      fetch_q      <= fetch_d;
      rd_hit_q     <= rd_hit_d;
      issue_q      <= issue_d;
      have_start_q <= have_start_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    newest_q <= newest_d;
    oldest_q <= oldest_d;
    qtag_q   <= qtag_d;
    t0_q     <= t0_d;
    ttime_q  <= ttime_d;
    res_q    <= res_d;
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.fill_count   = res_q.fill_count;
  assign res_o.read_valid   = res_q.read_valid;
  assign res_o.read_stamp   = res_q.read_stamp;
  assign res_o.read_tag     = res_q.read_tag;
  assign res_o.read_code    = res_q.read_code;
  assign res_o.newest_stamp = res_q.newest_stamp;
  assign res_o.newest_tag   = res_q.newest_tag;
  assign res_o.newest_code  = res_q.newest_code;
  assign res_o.span_ms      = res_q.span_ms;
  assign res_o.tag_time_ms  = res_q.tag_time_ms;

`ifndef SYNTHESIS
  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(LOG_DEPTH))
    else $error("fill count beyond depth");

  a_wp_tracks_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (CNT_W'(wp_q) == total_q))
    else $error("write pointer and fill count disagree before wrap");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (evt_i.command == CMD_CLEAR)) |=> (total_q == '0))
    else $error("clear left entries behind");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (evt_i.command == CMD_APPEND) && !full)
      |=> (total_q == $past(total_q) + 1'b1))
    else $error("append did not grow the log");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (pos_q <= total_q))
    else $error("scan ran past the fill count");
`endif

endmodule
`default_nettype wire

FILE: sim/wraparound_event_log_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wraparound event log buffer testbench
// Drives command beats and register writes into the event log and predicts
// every result beat from a shadow copy of the ring. Each result beat is
// checked field by field against the oldest prediction. A directed opening
// covers the corner cases. Phases of random traffic with several start and
// end code settings follow, with bursts of idling on both channels.
// ----------------------------------------------------------------------------
module wraparound_event_log_buffer_tb;
  import welb_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_BEATS  = 320;

  // Shadow copy of the log that predicts each result beat.
  class event_log_scoreboard;
    entry_t            ring [LOG_DEPTH];
    int unsigned       wr_slot;
    int unsigned       held;
    logic [CODE_W-1:0] start_code;
    logic [CODE_W-1:0] end_code;
    res_t              due_reports [$];
    int unsigned       faults;

    function new();
      wr_slot    = 0;
      held       = 0;
      start_code = START_CODE_RST;
      end_code   = END_CODE_RST;
      faults     = 0;
    endfunction

    function void set_code(reg_idx_e which, logic [CODE_W-1:0] value);
      if (which == REG_START_CODE) start_code = value;
      else end_code = value;
    endfunction

    // Physical slot of the entry at an oldest-first position.
    function logic [IDX_W-1:0] slot_of_age(int unsigned pos);
      int unsigned base;
      base = (held < LOG_DEPTH) ? 0 : wr_slot;
      return IDX_W'((base + pos) % LOG_DEPTH);
    endfunction

    function void log_command(cmd_e cmd, logic [TAG_W-1:0] tag, logic [STAMP_W-1:0] stamp,
                              logic [CODE_W-1:0] code, logic [RIDX_W-1:0] ridx);
      res_t               r;
      entry_t             e;
      bit                 started;
      logic [STAMP_W-1:0] t0;
      r       = '0;
      started = 1'b0;
      t0      = '0;
      case (cmd)
        CMD_APPEND: begin
          e.stamp = stamp;
          e.tag   = tag;
          e.code  = code;
          ring[IDX_W'(wr_slot)] = e;
          wr_slot = (wr_slot + 1) % LOG_DEPTH;
          if (held < LOG_DEPTH) held++;
        end
        CMD_READ: begin
          if (ridx < held) begin
            e = ring[slot_of_age(ridx)];
            r.read_valid = 1'b1;
            r.read_stamp = e.stamp;
            r.read_tag   = e.tag;
            r.read_code  = e.code;
          end
        end
        CMD_QUERY: begin
          for (int unsigned i = 0; i < held; i++) begin
            e = ring[slot_of_age(i)];
            if (e.tag != tag) continue;
            if (e.code == start_code && !started) begin
              t0      = e.stamp;
              started = 1'b1;
            end else if (e.code == end_code && started) begin
              r.tag_time_ms = e.stamp - t0;
              break;
            end
          end
        end
        default: begin
          wr_slot = 0;
          held    = 0;
        end
      endcase
      r.fill_count = CNT_W'(held);
      if (held > 0) begin
        e = ring[IDX_W'((wr_slot + LOG_DEPTH - 1) % LOG_DEPTH)];
        r.newest_stamp = e.stamp;
        r.newest_tag   = e.tag;
        r.newest_code  = e.code;
        if (held >= 2) r.span_ms = e.stamp - ring[slot_of_age(0)].stamp;
      end
      due_reports.push_back(r);
    endfunction

    function void compare(string field, logic [STAMP_W-1:0] want, logic [STAMP_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
        faults++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: result beat with nothing outstanding: expected none, got %h",
                 $time, got);
        faults++;
        return;
      end
      want = due_reports.pop_front();
      compare("fill_count",   STAMP_W'(want.fill_count),  STAMP_W'(got.fill_count));
      compare("read_valid",   STAMP_W'(want.read_valid),  STAMP_W'(got.read_valid));
      compare("read_stamp",   want.read_stamp,            got.read_stamp);
      compare("read_tag",     STAMP_W'(want.read_tag),    STAMP_W'(got.read_tag));
      compare("read_code",    STAMP_W'(want.read_code),   STAMP_W'(got.read_code));
      compare("newest_stamp", want.newest_stamp,          got.newest_stamp);
      compare("newest_tag",   STAMP_W'(want.newest_tag),  STAMP_W'(got.newest_tag));
      compare("newest_code",  STAMP_W'(want.newest_code), STAMP_W'(got.newest_code));
      compare("span_ms",      want.span_ms,               got.span_ms);
      compare("tag_time_ms",  want.tag_time_ms,           got.tag_time_ms);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  welb_in_if  evt_if ();
  welb_out_if res_if ();

  event_log_scoreboard sb = new();
  bit                  calm = 1'b0;
  logic [TAG_W-1:0]    tag_pool [3];
  logic [STAMP_W-1:0]  clock_ms = '0;
  res_t                seen_beat;

  wraparound_event_log_buffer u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #25_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result sink: stalls in short random bursts until the calm stretch.
  initial begin
    int stall;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 3);
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen_beat.fill_count   = res_if.fill_count;
      seen_beat.read_valid   = res_if.read_valid;
      seen_beat.read_stamp   = res_if.read_stamp;
      seen_beat.read_tag     = res_if.read_tag;
      seen_beat.read_code    = res_if.read_code;
      seen_beat.newest_stamp = res_if.newest_stamp;
      seen_beat.newest_tag   = res_if.newest_tag;
      seen_beat.newest_code  = res_if.newest_code;
      seen_beat.span_ms      = res_if.span_ms;
      seen_beat.tag_time_ms  = res_if.tag_time_ms;
      sb.check_result(seen_beat);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(cmd_e cmd, logic [TAG_W-1:0] tag, logic [STAMP_W-1:0] stamp,
                       logic [CODE_W-1:0] code, logic [RIDX_W-1:0] ridx);
    if (!calm && $urandom_range(0, 4) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    evt_if.valid      <= 1'b1;
    evt_if.command    <= cmd;
    evt_if.tag        <= tag;
    evt_if.stamp      <= stamp;
    evt_if.event_code <= code;
    evt_if.read_index <= ridx;
    do @(posedge clk_i); while (!evt_if.ready);
    sb.log_command(cmd, tag, stamp, code, ridx);
    @(negedge clk_i);
  endtask

  task automatic settle();
    evt_if.valid <= 1'b0;
    while (sb.due_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Each access ends with the bus back at idle (psel and penable low) before the task returns.
  task automatic apb_access(bit wr, reg_idx_e which, logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'(int'(which) * 4);
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic program_code(reg_idx_e which, logic [CODE_W-1:0] value);
    logic [APB_DATA_W-1:0] back;
    apb_access(1'b1, which, APB_DATA_W'(value), back);
    sb.set_code(which, value);
    apb_access(1'b0, which, '0, back);
    if (back !== APB_DATA_W'(value)) begin
      $display("%0t: %s readback mismatch: expected %0h, got %0h",
               $time, which.name(), value, back);
      sb.faults++;
    end
  endtask

  // Mostly well-formed traffic: a few tags per phase, codes biased to the
  // start and end codes, stamps from a slowly advancing clock.
  task automatic random_item();
    int unsigned        pick;
    cmd_e               cmd;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
    logic [CODE_W-1:0]  code;
    logic [RIDX_W-1:0]  ridx;
    pick = $urandom_range(0, 999);
    if (pick < 500) cmd = CMD_APPEND;
    else if (pick < 700) cmd = CMD_READ;
    else if (pick < 997) cmd = CMD_QUERY;
    else cmd = CMD_CLEAR;
    tag = ($urandom_range(0, 3) != 0) ? tag_pool[2'($urandom_range(0, 2))]
                                      : TAG_W'($urandom);
    clock_ms = clock_ms + $urandom_range(0, 2000);
    stamp = ($urandom_range(0, 9) == 0) ? STAMP_W'($urandom) : clock_ms;
    pick = $urandom_range(0, 9);
    code = (pick < 4) ? sb.start_code : (pick < 8) ? sb.end_code : CODE_W'($urandom);
    if (sb.held != 0 && $urandom_range(0, 3) != 0) ridx = RIDX_W'($urandom_range(0, sb.held - 1));
    else ridx = RIDX_W'($urandom);
    issue(cmd, tag, stamp, code, ridx);
  endtask

  initial begin
    rst_ni            = 1'b0;
    evt_if.valid      = 1'b0;
    evt_if.command    = CMD_APPEND;
    evt_if.tag        = '0;
    evt_if.stamp      = '0;
    evt_if.event_code = '0;
    evt_if.read_index = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty log, then extremes of stamp, tag and code with wrapping spans.
    issue(CMD_READ,   8'h00, 32'h0,         8'h00, 8'd0);
    issue(CMD_QUERY,  8'h00, 32'h0,         8'h00, 8'd0);
    issue(CMD_APPEND, 8'h00, 32'h0,         START_CODE_RST, 8'd0);
    issue(CMD_READ,   8'h00, 32'h0,         8'h00, 8'd0);
    issue(CMD_APPEND, 8'h00, 32'hFFFF_FFFF, END_CODE_RST, 8'hFF);
    issue(CMD_QUERY,  8'h00, 32'h0,         8'h00, 8'd0);
    issue(CMD_APPEND, 8'hFF, 32'd10,        8'hFF, 8'd0);
    issue(CMD_APPEND, 8'hFF, 32'd5,         START_CODE_RST, 8'd0);
    issue(CMD_APPEND, 8'hFF, 32'd3,         END_CODE_RST, 8'd0);
    issue(CMD_QUERY,  8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    issue(CMD_QUERY,  8'h55, 32'h0,         8'h00, 8'd0);
    issue(CMD_READ,   8'h00, 32'h0,         8'h00, 8'd255);
    issue(CMD_READ,   8'h00, 32'h0,         8'h00, 8'd4);
    issue(CMD_READ,   8'h00, 32'h0,         8'h00, 8'd5);
    issue(CMD_CLEAR,  8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    issue(CMD_READ,   8'h00, 32'h0,         8'h00, 8'd0);
    issue(CMD_QUERY,  8'h00, 32'h0,         8'h00, 8'd0);
    // An end before any start must not count.
    issue(CMD_APPEND, 8'hAA, 32'h1234_5678, END_CODE_RST, 8'd0);
    issue(CMD_APPEND, 8'hAA, 32'd100,       START_CODE_RST, 8'd0);
    issue(CMD_QUERY,  8'hAA, 32'h0,         8'h00, 8'd0);
    issue(CMD_APPEND, 8'hAA, 32'd40,        END_CODE_RST, 8'd0);
    issue(CMD_QUERY,  8'hAA, 32'h0,         8'h00, 8'd0);
    issue(CMD_READ,   8'h00, 32'h0,         8'h00, 8'd1);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: begin
            program_code(REG_START_CODE, 8'd0);
            program_code(REG_END_CODE, 8'd255);
          end
          2: begin
            program_code(REG_START_CODE, 8'd255);
            program_code(REG_END_CODE, 8'd0);
          end
          3: begin
            // Equal codes: successive matching entries pair up.
            program_code(REG_START_CODE, 8'd7);
            program_code(REG_END_CODE, 8'd7);
          end
          default: begin
            program_code(REG_START_CODE, CODE_W'($urandom));
            program_code(REG_END_CODE, CODE_W'($urandom));
          end
        endcase
      end
      if (phase == PHASES - 1) calm = 1'b1;
      for (int k = 0; k < 3; k++) tag_pool[2'(k)] = TAG_W'($urandom);
      repeat (PHASE_BEATS) random_item();
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (sb.faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
